FILE: hw/rtl/fraction_arithmetic_reduce_core_macros.svh
`ifndef FRACTION_ARITHMETIC_REDUCE_CORE_MACROS_SVH
`define FRACTION_ARITHMETIC_REDUCE_CORE_MACROS_SVH

// same-cycle implication
`define FRAC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FRAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/frac_pkg.sv
package frac_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int MAX_PW            = 64;
  localparam int RES_W             = 33;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MS_NONE = 2'd0,
    MS_DEN  = 2'd1,
    MS_NUM1 = 2'd2,
    MS_NUM2 = 2'd3
  } mul_sel_t;

  typedef enum logic [3:0] {
    ACT_NONE     = 4'd0,
    ACT_LOAD_D   = 4'd1,
    ACT_LOAD_N   = 4'd2,
    ACT_ACC_N    = 4'd3,
    ACT_GCD_INIT = 4'd4,
    ACT_GCD_STEP = 4'd5,
    ACT_DIV_INIT = 4'd6,
    ACT_DIV_STEP = 4'd7,
    ACT_OUTPUT   = 4'd8
  } act_t;

  typedef enum logic [1:0] {
    C_NONE   = 2'd0,
    C_ERR    = 2'd1,
    C_U_NZ   = 2'd2,
    C_CNT_NZ = 2'd3
  } cond_t;

  typedef logic [3:0] pc_t;

  localparam pc_t PC_CHECK    = 4'd0;
  localparam pc_t PC_MUL_DEN  = 4'd1;
  localparam pc_t PC_MUL_N1   = 4'd2;
  localparam pc_t PC_MUL_N2   = 4'd3;
  localparam pc_t PC_ACC      = 4'd4;
  localparam pc_t PC_GCD_INIT = 4'd5;
  localparam pc_t PC_GCD      = 4'd6;
  localparam pc_t PC_DIV_INIT = 4'd7;
  localparam pc_t PC_DIV      = 4'd8;
  localparam pc_t PC_OUT      = 4'd9;

  typedef struct packed {
    mul_sel_t mul_sel;
    act_t     act;
    cond_t    cond;
    pc_t      target;
  } ctrl_t;

  typedef struct packed {
    logic err;
    logic u_nz;
    logic cnt_nz;
    logic out_busy;
  } flags_t;

  // microcode: a taken jump goes to target, otherwise fall through
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t cw;
    cw = '{mul_sel: MS_NONE, act: ACT_NONE, cond: C_NONE, target: PC_CHECK};
    unique case (pc)
      PC_CHECK:    cw = '{MS_NONE, ACT_NONE,     C_ERR,    PC_OUT};
      PC_MUL_DEN:  cw = '{MS_DEN,  ACT_NONE,     C_NONE,   PC_CHECK};
      PC_MUL_N1:   cw = '{MS_NUM1, ACT_LOAD_D,   C_NONE,   PC_CHECK};
      PC_MUL_N2:   cw = '{MS_NUM2, ACT_LOAD_N,   C_NONE,   PC_CHECK};
      PC_ACC:      cw = '{MS_NONE, ACT_ACC_N,    C_NONE,   PC_CHECK};
      PC_GCD_INIT: cw = '{MS_NONE, ACT_GCD_INIT, C_NONE,   PC_CHECK};
      PC_GCD:      cw = '{MS_NONE, ACT_GCD_STEP, C_U_NZ,   PC_GCD};
      PC_DIV_INIT: cw = '{MS_NONE, ACT_DIV_INIT, C_NONE,   PC_CHECK};
      PC_DIV:      cw = '{MS_NONE, ACT_DIV_STEP, C_CNT_NZ, PC_DIV};
      PC_OUT:      cw = '{MS_NONE, ACT_OUTPUT,   C_NONE,   PC_CHECK};
      default:     cw = '{MS_NONE, ACT_OUTPUT,   C_NONE,   PC_CHECK};
    endcase
    return cw;
  endfunction

endpackage

FILE: hw/rtl/frac_in_if.sv
interface frac_in_if #(
  parameter int OPERAND_WIDTH = frac_pkg::OPERAND_WIDTH_DEF
);
  import frac_pkg::*;

  logic                            valid;
  logic                            ready;
  func_t                           func;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic signed [OPERAND_WIDTH-1:0] a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic signed [OPERAND_WIDTH-1:0] b_den;

  modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

FILE: hw/rtl/frac_out_if.sv
interface frac_out_if;
  import frac_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] res_num;
  logic signed [RES_W-1:0] res_den;
  status_t                 status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

FILE: hw/rtl/frac_useq.sv
module frac_useq (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  frac_pkg::flags_t flags,
  output logic             busy,
  output frac_pkg::ctrl_t  cw,
  output logic             exec
);
  import frac_pkg::*;

  pc_t  pc;
  logic taken;
  logic stall;

  assign cw = ucode(pc);

  always_comb begin
    unique case (cw.cond)
      C_NONE:   taken = 1'b0;
      C_ERR:    taken = flags.err;
      C_U_NZ:   taken = flags.u_nz;
      C_CNT_NZ: taken = flags.cnt_nz;
      default:  taken = 1'b0;
    endcase
  end

  // the final step waits until the output register is free
  assign stall = (cw.act == ACT_OUTPUT) && flags.out_busy;
  assign exec  = busy && !stall && ((cw.cond == C_NONE) || taken);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PC_CHECK;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= PC_CHECK;
    end else if (busy && !stall) begin
      if (cw.act == ACT_OUTPUT) begin
        busy <= 1'b0;
      end
      pc <= taken ? cw.target : pc_t'(pc + 1'b1);
    end
  end

endmodule

FILE: hw/rtl/fraction_arithmetic_reduce_core.sv
// Adds, subtracts, multiplies or divides two signed fractions and reduces the
// result by the gcd of its magnitudes, signs kept as computed (the denominator
// may come out negative). One item is worked at a time; ready is low from
// acceptance until the result has been loaded into the output register, so a
// result may wait there while the next item is accepted. A microcode sequencer
// steps one shared OPERAND_WIDTH x OPERAND_WIDTH multiplier through up to three
// products, then a binary gcd loop (one step a cycle) and a two-lane restoring
// divider of width P = 2*OPERAND_WIDTH+1 capped at 64 (one quotient bit a cycle
// on numerator and denominator together). An item with a zero denominator, or a
// divide by a zero fraction, skips the arithmetic and returns 0/0 with a nonzero
// status.
`include "fraction_arithmetic_reduce_core_macros.svh"

module fraction_arithmetic_reduce_core #(
  parameter int OPERAND_WIDTH = frac_pkg::OPERAND_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  frac_in_if.sink   arg,
  frac_out_if.source res
);
  import frac_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = (2 * W + 1 > MAX_PW) ? MAX_PW : 2 * W + 1;
  localparam int KW = $clog2(PW);
  localparam int CW = $clog2(PW + 1);
  localparam int XW = (PW > RES_W) ? PW : RES_W;

  logic   busy;
  logic   exec;
  ctrl_t  cw;
  flags_t flags;
  logic   start;

  func_t               op;
  logic signed [W-1:0] an, ad, bn, bd;
  status_t             status_q;

  logic signed [W-1:0]   mul_a, mul_b;
  logic signed [2*W-1:0] prod;
  logic signed [PW-1:0]  prod_ext;
  logic signed [PW-1:0]  n, d;
  logic [PW-1:0]         mag_n, mag_d;

  logic [PW-1:0] u, v;
  logic [KW-1:0] k;

  logic [PW-1:0] xn, xd, rn, rd;
  logic [CW-1:0] cnt;
  logic [PW:0]   tn, td, dn, dd;
  logic          ge_n, ge_d;

  logic signed [PW-1:0] qn, qd;
  logic signed [XW-1:0] qn_ext, qd_ext;

  assign start     = arg.valid && arg.ready;
  assign arg.ready = !busy && !rst;

  assign flags.err      = (status_q != ST_OK);
  assign flags.u_nz     = (u != '0);
  assign flags.cnt_nz   = (cnt != '0);
  assign flags.out_busy = res.valid && !res.ready;

  frac_useq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .busy  (busy),
    .cw    (cw),
    .exec  (exec)
  );

  always_comb begin
    unique case (cw.mul_sel)
      MS_DEN: begin
        mul_a = ad;
        mul_b = (op == FUNC_DIV) ? bn : bd;
      end
      MS_NUM1: begin
        mul_a = an;
        mul_b = (op == FUNC_MUL) ? bn : bd;
      end
      MS_NUM2: begin
        mul_a = bn;
        mul_b = ad;
      end
      default: begin
        mul_a = ad;
        mul_b = bd;
      end
    endcase
  end

  assign prod_ext = PW'(prod);
  assign mag_n    = n[PW-1] ? PW'(-n) : PW'(n);
  assign mag_d    = d[PW-1] ? PW'(-d) : PW'(d);

  // division lanes share the odd gcd part as divisor
  assign tn   = {rn, xn[PW-1]};
  assign td   = {rd, xd[PW-1]};
  assign ge_n = (tn >= {1'b0, v});
  assign ge_d = (td >= {1'b0, v});
  assign dn   = tn - {1'b0, v};
  assign dd   = td - {1'b0, v};

  assign qn     = n[PW-1] ? PW'(-xn) : PW'(xn);
  assign qd     = d[PW-1] ? PW'(-xd) : PW'(xd);
  assign qn_ext = XW'(qn);
  assign qd_ext = XW'(qd);

  always_ff @(posedge clk) begin
    if (start) begin
      op <= arg.func;
      an <= arg.a_num;
      ad <= arg.a_den;
      bn <= arg.b_num;
      bd <= arg.b_den;
      if (arg.a_den == '0 || arg.b_den == '0) begin
        status_q <= ST_ZERO_DEN;
      end else if (arg.func == FUNC_DIV && arg.b_num == '0) begin
        status_q <= ST_DIV_ZERO;
      end else begin
        status_q <= ST_OK;
      end
    end
    if (exec && cw.mul_sel != MS_NONE) begin
      prod <= mul_a * mul_b;
    end
    if (exec) begin
      unique case (cw.act)
        ACT_LOAD_D: d <= prod_ext;
        ACT_LOAD_N: n <= prod_ext;
        ACT_ACC_N: begin
          if (op == FUNC_ADD) begin
            n <= n + prod_ext;
          end else if (op == FUNC_SUB) begin
            n <= n - prod_ext;
          end
        end
        ACT_GCD_INIT: begin
          u <= mag_n;
          v <= mag_d;
          k <= '0;
        end
        ACT_GCD_STEP: begin
          priority if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= KW'(k + 1'b1);
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u >= v) begin
            u <= (u - v) >> 1;
          end else begin
            v <= (v - u) >> 1;
          end
        end
        ACT_DIV_INIT: begin
          xn  <= mag_n >> k;
          xd  <= mag_d >> k;
          rn  <= '0;
          rd  <= '0;
          cnt <= CW'(PW);
        end
        ACT_DIV_STEP: begin
          rn  <= ge_n ? dn[PW-1:0] : tn[PW-1:0];
          rd  <= ge_d ? dd[PW-1:0] : td[PW-1:0];
          xn  <= {xn[PW-2:0], ge_n};
          xd  <= {xd[PW-2:0], ge_d};
          cnt <= CW'(cnt - 1'b1);
        end
        ACT_NONE, ACT_OUTPUT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (exec && cw.act == ACT_OUTPUT) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && cw.act == ACT_OUTPUT) begin
      res.status <= status_q;
      if (status_q == ST_OK) begin
        res.res_num <= qn_ext[RES_W-1:0];
        res.res_den <= qd_ext[RES_W-1:0];
      end else begin
        res.res_num <= '0;
        res.res_den <= '0;
      end
    end
  end

  `FRAC_ASSERT_NOW(a_err_zero, res.valid && res.status != ST_OK, res.res_num == '0 && res.res_den == '0, "error item with nonzero fraction")
  `FRAC_ASSERT_NEXT(a_start_busy, start, busy && !arg.ready, "sequencer not started on accept")
  `FRAC_ASSERT_NOW(a_gcd_v_nz, busy && cw.act == ACT_GCD_STEP, v != '0, "gcd divisor reached zero")
  `FRAC_ASSERT_NOW(a_div_rem, busy && cw.act == ACT_DIV_STEP, rn < v && rd < v, "remainder not below divisor")

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import frac_pkg::*;

  localparam int OW          = OPERAND_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CALM_ITEMS  = 150;
  localparam int LONG_HOLD   = 600;
  localparam int DRAIN_WAIT  = 150;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic signed [RES_W-1:0] num;
    logic signed [RES_W-1:0] den;
    status_t                 status;
  } frac_result_t;

  typedef struct {
    func_t               op;
    logic signed [OW-1:0] an;
    logic signed [OW-1:0] ad;
    logic signed [OW-1:0] bn;
    logic signed [OW-1:0] bd;
    bit                  known;
    frac_result_t        want;
  } stim_row_t;

  logic clk;
  logic rst;

  frac_in_if #(.OPERAND_WIDTH(OW)) arg_if ();
  frac_out_if res_if ();

  fraction_arithmetic_reduce_core #(.OPERAND_WIDTH(OW)) DUT (
    .clk (clk),
    .rst (rst),
    .arg (arg_if),
    .res (res_if)
  );

  frac_result_t results_due[$];
  stim_row_t    directed_rows[$];
  int           mismatches   = 0;
  int           cycle_count  = 0;
  int           idle_odds    = 2;
  bit           calm         = 1'b0;
  bit           hold_request = 1'b0;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // predictor: 64-bit wrapping arithmetic, reduced by the gcd of the magnitudes
  function automatic frac_result_t reduce_fraction(input func_t op,
      input logic signed [OW-1:0] an, input logic signed [OW-1:0] ad,
      input logic signed [OW-1:0] bn, input logic signed [OW-1:0] bd);
    frac_result_t r;
    longint       n;
    longint       d;
    longint       x;
    longint       y;
    longint       t;
    r = '{num: '0, den: '0, status: ST_OK};
    if (ad == 0 || bd == 0) begin
      r.status = ST_ZERO_DEN;
      return r;
    end
    if (op == FUNC_DIV && bn == 0) begin
      r.status = ST_DIV_ZERO;
      return r;
    end
    case (op)
      FUNC_ADD: begin
        n = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
        d = longint'(ad) * longint'(bd);
      end
      FUNC_SUB: begin
        n = longint'(an) * longint'(bd) - longint'(bn) * longint'(ad);
        d = longint'(ad) * longint'(bd);
      end
      FUNC_MUL: begin
        n = longint'(an) * longint'(bn);
        d = longint'(ad) * longint'(bd);
      end
      default: begin
        n = longint'(an) * longint'(bd);
        d = longint'(ad) * longint'(bn);
      end
    endcase
    x = (n < 0) ? -n : n;
    y = (d < 0) ? -d : d;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x == 0) x = 1;
    n = n / x;
    d = d / x;
    r.num = n[RES_W-1:0];
    r.den = d[RES_W-1:0];
    return r;
  endfunction

  function automatic logic signed [OW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       pick_operand = {1'b1, {(OW-1){1'b0}}};
      1:       pick_operand = {1'b0, {(OW-1){1'b1}}};
      2, 3, 4: pick_operand = OW'(int'($urandom_range(0, 40)) - 20);
      default: pick_operand = OW'($urandom);
    endcase
  endfunction

  task automatic add_row(input func_t op, input int an, input int ad, input int bn,
                         input int bd);
    stim_row_t r;
    r.op    = op;
    r.an    = OW'(an);
    r.ad    = OW'(ad);
    r.bn    = OW'(bn);
    r.bd    = OW'(bd);
    r.known = 1'b0;
    r.want  = '{num: '0, den: '0, status: ST_OK};
    directed_rows.push_back(r);
  endtask

  task automatic add_known(input func_t op, input int an, input int ad, input int bn,
                           input int bd, input longint num, input longint den,
                           input status_t st);
    stim_row_t r;
    r.op    = op;
    r.an    = OW'(an);
    r.ad    = OW'(ad);
    r.bn    = OW'(bn);
    r.bd    = OW'(bd);
    r.known = 1'b1;
    r.want  = '{num: RES_W'(num), den: RES_W'(den), status: st};
    directed_rows.push_back(r);
  endtask

  task automatic offer(input stim_row_t r);
    if (!calm && idle_odds != 0 && $urandom_range(0, 7) < idle_odds) begin
      arg_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    arg_if.valid <= 1'b1;
    arg_if.func  <= r.op;
    arg_if.a_num <= r.an;
    arg_if.a_den <= r.ad;
    arg_if.b_num <= r.bn;
    arg_if.b_den <= r.bd;
    do @(posedge clk); while (!arg_if.ready);
    results_due.push_back(r.known ? r.want : reduce_fraction(r.op, r.an, r.ad, r.bn, r.bd));
  endtask

  // sender
  initial begin
    stim_row_t r;
    arg_if.valid <= 1'b0;
    arg_if.func  <= FUNC_ADD;
    arg_if.a_num <= '0;
    arg_if.a_den <= '0;
    arg_if.b_num <= '0;
    arg_if.b_den <= '0;

    add_known(FUNC_ADD, 0, 1, 0, 1, 0, 1, ST_OK);
    add_known(FUNC_ADD, 3, 0, 1, 2, 0, 0, ST_ZERO_DEN);
    add_known(FUNC_SUB, 1, 2, 5, 0, 0, 0, ST_ZERO_DEN);
    add_known(FUNC_DIV, 0, 0, 0, 0, 0, 0, ST_ZERO_DEN);
    add_known(FUNC_DIV, 1, 2, 0, 5, 0, 0, ST_DIV_ZERO);
    add_known(FUNC_DIV, -32768, -32768, 0, -32768, 0, 0, ST_DIV_ZERO);
    add_known(FUNC_MUL, -32768, 1, -32768, 1, 1073741824, 1, ST_OK);
    add_known(FUNC_MUL, 32767, -32768, 32767, -32768, 1073676289, 1073741824, ST_OK);
    add_known(FUNC_ADD, -32768, 1, -32768, 1, -65536, 1, ST_OK);
    add_known(FUNC_ADD, -32768, -32768, -32768, -32768, 2, 1, ST_OK);
    add_known(FUNC_SUB, 0, -3, 0, 7, 0, -1, ST_OK);
    add_known(FUNC_MUL, 0, 5, 7, 3, 0, 1, ST_OK);
    add_known(FUNC_DIV, 5, 1, -1, 1, 5, -1, ST_OK);
    add_known(FUNC_DIV, -32768, -32768, -32768, -32768, 1, 1, ST_OK);
    add_known(FUNC_SUB, 7, 3, 7, 3, 0, 1, ST_OK);
    add_known(FUNC_MUL, 32767, 32767, -32768, -32768, -1, -1, ST_OK);
    add_row(FUNC_ADD, 1, 2, 1, 3);
    add_row(FUNC_SUB, 1, 2, 1, 3);
    add_row(FUNC_MUL, -3, 4, 2, -9);
    add_row(FUNC_DIV, 7, -12, -14, 3);
    add_row(FUNC_ADD, -32768, 32767, 32767, -32768);
    add_row(FUNC_SUB, -32768, -32768, 32767, -32768);
    add_row(FUNC_ADD, -32768, 32767, -32768, 32767);
    add_row(FUNC_DIV, 32767, -32768, -32768, 32767);
    add_row(FUNC_SUB, 32767, 1, -32768, 1);

    wait (!rst);
    @(posedge clk);

    foreach (directed_rows[i]) offer(directed_rows[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) idle_odds = $urandom_range(0, 3);
      calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
      if (i == 300) hold_request = 1'b1;
      if (i == 700) begin
        // let the block drain completely before carrying on
        arg_if.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      r.op    = func_t'($urandom_range(0, 3));
      r.an    = pick_operand();
      r.ad    = ($urandom_range(0, 24) == 0) ? '0 : pick_operand();
      r.bn    = (r.op == FUNC_DIV && $urandom_range(0, 15) == 0) ? '0 : pick_operand();
      r.bd    = ($urandom_range(0, 24) == 0) ? '0 : pick_operand();
      r.known = 1'b0;
      offer(r);
    end
    arg_if.valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // receiver
  initial begin
    res_if.ready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(100, 400)) @(posedge clk);
      else
        repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    frac_result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected item %0d/%0d status %0d", $time,
                 res_if.res_num, res_if.res_den, res_if.status);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (res_if.res_num !== want.num) begin
          $display("%0t: res_num expected %0d got %0d", $time, want.num, res_if.res_num);
          mismatches++;
        end
        if (res_if.res_den !== want.den) begin
          $display("%0t: res_den expected %0d got %0d", $time, want.den, res_if.res_den);
          mismatches++;
        end
        if (res_if.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, res_if.status);
          mismatches++;
        end
      end
    end
  end

endmodule
